### rtl/twd_pkg.sv
// Shared types, codes and constants of the heartbeat watchdog.
package twd_pkg;

    localparam int TWD_MAX_SLOTS = 8;
    localparam int CFG_AW        = 3;

    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [7:0]  MAXREC_RESET  = 8'd3;

    localparam logic [7:0] WAKE_NONE    = 8'h00;
    localparam logic [7:0] WAKE_RECOVER = 8'h01;
    localparam logic [7:0] WAKE_FORCE   = 8'hFF;

    // register word index, taken from paddr[2]
    localparam logic REG_TIMEOUT_IDX = 1'b0;
    localparam logic REG_MAXREC_IDX  = 1'b1;

    typedef enum logic [1:0] {
        KIND_REGISTER = 2'd0,
        KIND_KICK     = 2'd1,
        KIND_CHECK    = 2'd2,
        KIND_FORCE    = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_REGISTERED = 4'd0,
        ST_FULL       = 4'd1,
        ST_KICKED     = 4'd2,
        ST_NOT_FOUND  = 4'd3,
        ST_OK         = 4'd4,
        ST_EMPTY      = 4'd5,
        ST_REMOVED    = 4'd6,
        ST_NOTIFIED   = 4'd7,
        ST_LIMIT      = 4'd8,
        ST_RECOVERED  = 4'd9,
        ST_FORCED     = 4'd10,
        ST_NO_SLOTS   = 4'd11
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_EMIT1
    } state_t;

    typedef struct packed {
        logic [15:0] client;
        logic [31:0] last_seen;
        logic [31:0] tmo_cnt;
        logic [7:0]  rec_cnt;
    } slot_ent_t;

    typedef struct packed {
        logic      emit;
        status_t   status;
        logic [7:0] wake;
        slot_ent_t ent;
        logic      wr;
        logic      drop;
        logic      bump_tmo;
        logic      bump_wake;
    } slot_upd_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

### rtl/task_heartbeat_watchdog.sv
// Heartbeat watchdog top level: slot sequencer, counters and result register.
//
// Watches up to MAX_SLOTS clients held in slots that fill in order and are
// never reused. One transaction is handled at a time; item_stall stays high
// until its last result has been loaded into the result register. Register,
// and any transaction while no slot is in use, goes straight to the emit
// state S_EMIT1. Kick, check and force walk the slots in use one after
// another through a single slot update unit, each slot taking a memory
// read, then evaluate and write back; a check or force visits every slot in
// use and a kick stops at the first match. Every slot result waits while
// the result register is held by result_stall. Slot records live in a
// memory with no reset; only slots already handed out are ever read.
module task_heartbeat_watchdog
    import twd_pkg::*;
#(
    parameter int MAX_SLOTS = TWD_MAX_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        kind,
    input  logic [15:0]       client_key,
    input  logic [31:0]       now_ticks,
    input  logic [7:0]        deleted_mask,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [2:0]        slot_index,
    output logic [3:0]        status,
    output logic [7:0]        wake_bits,
    output logic [15:0]       slot_key,
    output logic [31:0]       slot_timeouts,
    output logic [7:0]        slot_recoveries,
    output logic [31:0]       deadlock_total,
    output logic [31:0]       recovery_total,
    output logic              last
);

    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int USED_W = $clog2(MAX_SLOTS + 1);
    localparam int ENT_W  = $bits(slot_ent_t);

    logic [31:0] timeout_ticks;
    logic [7:0]  max_recoveries;

    state_t      state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0] tot_tmo_reg, tot_tmo_next;
    logic [31:0] tot_wake_reg, tot_wake_next;

    kind_t       kind_reg;
    logic [15:0] key_reg;
    logic [31:0] now_reg;
    logic [7:0]  dmask_reg;

    logic        ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_ent_t   ram_wdata;
    logic        ram_re;
    logic [ENT_W-1:0] ram_rdata;
    slot_ent_t   rd_ent;

    slot_upd_t   upd;
    logic [6:0]  idx7;
    logic        gone;
    logic        last_slot;
    logic        out_free;
    logic        accept;

    logic        emit;
    logic [2:0]  res_index;
    status_t     res_status;
    logic [7:0]  res_wake;
    logic [15:0] res_key;
    logic [31:0] res_tmo;
    logic [7:0]  res_rec;
    logic        res_last;

    logic        rv_reg;
    logic [2:0]  index_reg;
    status_t     status_reg;
    logic [7:0]  wake_reg;
    logic [15:0] skey_reg;
    logic [31:0] stmo_reg;
    logic [7:0]  srec_reg;
    logic [31:0] dtot_reg;
    logic [31:0] rtot_reg;
    logic        last_reg;

    twd_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .timeout_ticks  (timeout_ticks),
        .max_recoveries (max_recoveries)
    );

    twd_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IDX_W),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_ent = slot_ent_t'(ram_rdata);

    // deleted mask only covers the first eight slots
    assign idx7      = 7'(idx_reg);
    assign gone      = (idx7 < 7'd8) && dmask_reg[idx7[2:0]];
    assign last_slot = (USED_W'(USED_W'(idx_reg) + USED_W'(1)) == used_reg);

    twd_slot_unit u_unit (
        .kind           (kind_reg),
        .ent            (rd_ent),
        .ent_valid      (valid_reg[idx_reg]),
        .gone           (gone),
        .key            (key_reg),
        .now_ticks      (now_reg),
        .timeout_ticks  (timeout_ticks),
        .max_recoveries (max_recoveries),
        .upd            (upd)
    );

    assign out_free   = !rv_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            used_reg     <= '0;
            valid_reg    <= '0;
            tot_tmo_reg  <= '0;
            tot_wake_reg <= '0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            used_reg     <= used_next;
            valid_reg    <= valid_next;
            tot_tmo_reg  <= tot_tmo_next;
            tot_wake_reg <= tot_wake_next;
            if (emit)
            begin
                rv_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(kind);
            key_reg   <= client_key;
            now_reg   <= now_ticks;
            dmask_reg <= deleted_mask;
        end
        if (emit)
        begin
            index_reg  <= res_index;
            status_reg <= res_status;
            wake_reg   <= res_wake;
            skey_reg   <= res_key;
            stmo_reg   <= res_tmo;
            srec_reg   <= res_rec;
            dtot_reg   <= tot_tmo_next;
            rtot_reg   <= tot_wake_next;
            last_reg   <= res_last;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        valid_next    = valid_reg;
        tot_tmo_next  = tot_tmo_reg;
        tot_wake_next = tot_wake_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = upd.ent;
        ram_re        = 1'b0;
        emit          = 1'b0;
        res_index     = 3'(idx_reg);
        res_status    = upd.status;
        res_wake      = upd.wake;
        res_key       = upd.ent.client;
        res_tmo       = upd.ent.tmo_cnt;
        res_rec       = upd.ent.rec_cnt;
        res_last      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    idx_next = '0;
                    if ((kind_t'(kind) == KIND_REGISTER) || (used_reg == '0))
                    begin
                        state_next = S_EMIT1;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                // a kick that misses every slot reports once, on the last slot
                if (upd.emit || ((kind_reg == KIND_KICK) && last_slot))
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                    end
                end
                if (out_free || !(upd.emit || ((kind_reg == KIND_KICK) && last_slot)))
                begin
                    ram_we    = upd.wr;
                    ram_waddr = idx_reg;
                    if (upd.drop)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (upd.bump_tmo)
                    begin
                        tot_tmo_next = sat_inc(tot_tmo_reg);
                    end
                    if (upd.bump_wake)
                    begin
                        tot_wake_next = sat_inc(tot_wake_reg);
                    end
                    if (last_slot || ((kind_reg == KIND_KICK) && upd.emit))
                    begin
                        state_next = S_IDLE;
                        res_last   = 1'b1;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(idx_reg + IDX_W'(1));
                        state_next = S_READ;
                    end
                end
                if ((kind_reg == KIND_KICK) && !upd.emit)
                begin
                    res_index  = 3'd0;
                    res_status = ST_NOT_FOUND;
                    res_wake   = WAKE_NONE;
                    res_key    = key_reg;
                    res_tmo    = '0;
                    res_rec    = '0;
                end
            end
            S_EMIT1:
            begin
                res_index = 3'd0;
                res_wake  = WAKE_NONE;
                res_tmo   = '0;
                res_rec   = '0;
                res_last  = 1'b1;
                res_key   = key_reg;
                case (kind_reg)
                    KIND_REGISTER:
                    begin
                        if (used_reg >= USED_W'(MAX_SLOTS))
                        begin
                            res_status = ST_FULL;
                        end
                        else
                        begin
                            res_status = ST_REGISTERED;
                            res_index  = 3'(used_reg);
                        end
                    end
                    KIND_KICK:
                    begin
                        res_status = ST_NOT_FOUND;
                    end
                    default:
                    begin
                        res_status = ST_NO_SLOTS;
                        res_key    = '0;
                    end
                endcase
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if ((kind_reg == KIND_REGISTER) && (used_reg < USED_W'(MAX_SLOTS)))
                    begin
                        ram_we                             = 1'b1;
                        ram_waddr                          = used_reg[IDX_W-1:0];
                        ram_wdata                          = '0;
                        ram_wdata.client                   = key_reg;
                        ram_wdata.last_seen                = now_reg;
                        valid_next[used_reg[IDX_W-1:0]]    = 1'b1;
                        used_next                          = USED_W'(used_reg + USED_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result_valid    = rv_reg;
    assign slot_index      = index_reg;
    assign status          = status_reg;
    assign wake_bits       = wake_reg;
    assign slot_key        = skey_reg;
    assign slot_timeouts   = stmo_reg;
    assign slot_recoveries = srec_reg;
    assign deadlock_total  = dtot_reg;
    assign recovery_total  = rtot_reg;
    assign last            = last_reg;

endmodule

### rtl/twd_slot_ram.sv
// Slot record memory: one write port, one registered read port.
module twd_slot_ram
    import twd_pkg::*;
#(
    parameter int DEPTH = TWD_MAX_SLOTS,
    parameter int AW    = 3,
    parameter int WIDTH = $bits(slot_ent_t)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/twd_slot_unit.sv
// Per-slot update unit shared by kick, check and force walks.
module twd_slot_unit
    import twd_pkg::*;
(
    input  kind_t       kind,
    input  slot_ent_t   ent,
    input  logic        ent_valid,
    input  logic        gone,
    input  logic [15:0] key,
    input  logic [31:0] now_ticks,
    input  logic [31:0] timeout_ticks,
    input  logic [7:0]  max_recoveries,
    output slot_upd_t   upd
);

    logic [31:0] elapsed;

    assign elapsed = now_ticks - ent.last_seen;

    always_comb
    begin
        upd           = '0;
        upd.ent       = ent;
        upd.status    = ST_EMPTY;
        upd.wake      = WAKE_NONE;
        case (kind)
            KIND_KICK:
            begin
                if (ent_valid && (ent.client == key))
                begin
                    upd.emit          = 1'b1;
                    upd.status        = ST_KICKED;
                    upd.wr            = 1'b1;
                    upd.ent.last_seen = now_ticks;
                end
            end
            KIND_CHECK:
            begin
                upd.emit = 1'b1;
                if (!ent_valid)
                begin
                    upd.status = ST_EMPTY;
                end
                else if (gone)
                begin
                    upd.status = ST_REMOVED;
                    upd.drop   = 1'b1;
                end
                else if (elapsed > timeout_ticks)
                begin
                    upd.wr          = 1'b1;
                    upd.bump_tmo    = 1'b1;
                    upd.ent.tmo_cnt = sat_inc(ent.tmo_cnt);
                    if (ent.rec_cnt < max_recoveries)
                    begin
                        upd.bump_wake     = 1'b1;
                        upd.ent.rec_cnt   = ent.rec_cnt + 8'd1;
                        upd.ent.last_seen = now_ticks;
                        upd.status        = ST_NOTIFIED;
                        upd.wake          = WAKE_RECOVER;
                    end
                    else
                    begin
                        upd.status = ST_LIMIT;
                    end
                end
                else if (ent.tmo_cnt != 32'd0)
                begin
                    upd.wr          = 1'b1;
                    upd.ent.tmo_cnt = '0;
                    upd.ent.rec_cnt = '0;
                    upd.status      = ST_RECOVERED;
                end
                else
                begin
                    upd.status = ST_OK;
                end
            end
            KIND_FORCE:
            begin
                upd.emit = 1'b1;
                if (ent_valid)
                begin
                    upd.wr            = 1'b1;
                    upd.ent.last_seen = now_ticks;
                    upd.ent.tmo_cnt   = '0;
                    upd.ent.rec_cnt   = '0;
                    upd.status        = ST_FORCED;
                    upd.wake          = WAKE_FORCE;
                end
            end
            default:
            begin
                upd.emit = 1'b0;
            end
        endcase
    end

endmodule

### rtl/twd_cfg.sv
// APB configuration registers: timeout threshold and recovery limit.
module twd_cfg
    import twd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [31:0]       timeout_ticks,
    output logic [7:0]        max_recoveries
);

    logic [31:0] timeout_reg;
    logic [7:0]  maxrec_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            maxrec_reg  <= MAXREC_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_TIMEOUT_IDX: timeout_reg <= pwdata;
                REG_MAXREC_IDX:  maxrec_reg  <= pwdata[7:0];
                default:         timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TIMEOUT_IDX: prdata = timeout_reg;
            REG_MAXREC_IDX:  prdata = {24'd0, maxrec_reg};
            default:         prdata = '0;
        endcase
    end

    assign timeout_ticks  = timeout_reg;
    assign max_recoveries = maxrec_reg;

endmodule

### rtl/twd_checker.sv
// Port-level checks of the heartbeat watchdog, bound to the top level.
module twd_checker
    import twd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [2:0]  slot_index,
    input  logic [3:0]  status,
    input  logic [7:0]  wake_bits,
    input  logic [15:0] slot_key,
    input  logic [7:0]  slot_recoveries,
    input  logic        last
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(status) && $stable(slot_index)
            && $stable(slot_key) && $stable(last))
        else $error("result changed while stalled");

    a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (wake_bits != WAKE_NONE) |->
            (status == ST_NOTIFIED) || (status == ST_FORCED))
        else $error("wake bits on a result that sends no wake");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((status == ST_FULL) || (status == ST_NOT_FOUND)
            || (status == ST_NO_SLOTS) || (status == ST_REGISTERED)
            || (status == ST_KICKED)) |-> last)
        else $error("single-result transaction without last");

    a_notify_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_NOTIFIED) |->
            (slot_recoveries != 8'd0) && (wake_bits == WAKE_RECOVER))
        else $error("notification without a recovery attempt");

endmodule

bind task_heartbeat_watchdog twd_checker u_twd_checker (.*);
